// ===== hw/rtl/wpt_pkg.sv =====
// Shared types, constants and helper functions of the wildcard permission table.
package wpt_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int NAME_BYTES  = 16;
    localparam int HALF_BITS   = 64;
    localparam int NAME_BITS   = 2 * HALF_BITS;
    localparam int LEN_W       = 5;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int INDEX_W     = 8;
    localparam int ROOM_W      = 5;
    localparam int STATUS_W    = 3;
    localparam int TOTAL_W     = 5;

    // Request kinds.
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_REMOVE   = 2'd1;
    localparam logic [1:0] REQ_CONTAINS = 2'd2;
    localparam logic [1:0] REQ_READ_AT  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // ASCII characters used by validation and wildcard matching.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [HALF_BITS-1:0] name_low;
        logic [HALF_BITS-1:0] name_high;
        logic [LEN_W-1:0]     name_length;
        logic [INDEX_W-1:0]   entry_index;
        logic [ROOM_W-1:0]    buffer_room;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 found;
        logic                 name_ok;
        logic [HALF_BITS-1:0] entry_low;
        logic [HALF_BITS-1:0] entry_high;
        logic [LEN_W-1:0]     entry_length;
        logic [TOTAL_W-1:0]   entry_total;
    } rsp_item_t;

    // One stored name: bytes hold {high half, low half}, masked to the length.
    typedef struct packed {
        logic [LEN_W-1:0]     length;
        logic [NAME_BITS-1:0] bytes;
    } entry_t;

    typedef struct packed {
        logic add_here;
        logic remove_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic exact;
        logic match;
    } cell_flags_t;

    // All-ones over the first n bytes of a name.
    function automatic logic [NAME_BITS-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [NAME_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic char_ok(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               c == CH_DOT || c == CH_DASH || c == CH_UNDER ||
               c == CH_STAR || c == CH_COLON;
    endfunction

endpackage

// ===== hw/rtl/wildcard_permission_table.sv =====
// Top level of the wildcard permission table: request decode, cell row and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------
//  req     | in        | req_valid/req_stall| req_item_t
//  rsp     | out       | rsp_valid/rsp_stall| rsp_item_t
//
// Each item first has its masked name and validation flag registered in the
// request register; once the result register can take a new result, all cells
// compare against it in parallel, the table is updated and the result register
// is loaded. The row of cells is the only table storage, so one item is worked on at a time.
// Reset (rst_n, asynchronous) empties the table by clearing the entry count;
// the cells' contents are left as they are and are never read before written.
// A stalled result holds in its register while the next item is accepted; the
// item then waits in the request register until the result is taken.
module wildcard_permission_table
    import wpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    // Request held for the compare cycle.
    typedef struct packed {
        logic [1:0]         kind;
        entry_t             name;
        logic               name_ok;
        logic               fits;
        logic [INDEX_W-1:0] index;
        logic [ROOM_W-1:0]  room;
    } held_req_t;

    held_req_t            hold_reg;
    held_req_t            hold_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_item_t            rsp_reg;
    rsp_item_t            rsp_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    logic                 accept;
    logic                 fire;
    logic [LEN_W-1:0]     eff_len;
    logic                 name_ok;

    entry_t               cell_entry [MAX_ENTRIES];
    entry_t               cell_neighbor [MAX_ENTRIES];
    cell_ctrl_t           cell_ctrl [MAX_ENTRIES];
    cell_flags_t          cell_flags [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] seen_chain;
    logic [MAX_ENTRIES-1:0] exact_vec;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] read_sel;

    logic                 any_exact;
    logic                 any_match;
    logic                 full;
    logic                 add_ok;
    logic                 index_hit;
    entry_t               read_entry;

    // Handshake: a new item is taken only when the request register is free.
    assign accept    = req_valid && !busy_reg;
    assign fire      = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Input decode: clip the length, mask bytes past it, validate the characters.
    assign eff_len = (req.name_length > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES)
                                                            : req.name_length;

    always_comb
    begin
        name_ok = (req.name_length != '0) && (req.name_length <= LEN_W'(NAME_BYTES));
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (LEN_W'(b) < req.name_length)
            begin
                if (b < NAME_BYTES / 2)
                begin
                    name_ok = name_ok && char_ok(req.name_low[8*b +: 8]);
                end
                else
                begin
                    name_ok = name_ok && char_ok(req.name_high[8*(b - NAME_BYTES/2) +: 8]);
                end
            end
        end
    end

    always_comb
    begin
        hold_next             = hold_reg;
        if (accept)
        begin
            hold_next.kind        = req.req_type;
            hold_next.name.length = req.name_length;
            hold_next.name.bytes  = {req.name_high, req.name_low} & byte_mask(eff_len);
            hold_next.name_ok     = name_ok;
            hold_next.fits        = req.name_length <= LEN_W'(NAME_BYTES);
            hold_next.index       = req.entry_index;
            hold_next.room        = req.buffer_room;
        end
    end

    // Row of cells. Cell i holds table position i; remove shifts every entry
    // after the match one place down, the seen chain marking where that starts.
    assign seen_chain[0] = 1'b0;
    assign full          = count_reg >= COUNT_W'(MAX_ENTRIES);
    assign add_ok        = hold_reg.name_ok && !any_exact && !full;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            if (gi == MAX_ENTRIES - 1)
            begin : g_last
                assign cell_neighbor[gi] = '0;
            end
            else
            begin : g_mid
                assign cell_neighbor[gi] = cell_entry[gi + 1];
            end

            assign cell_ctrl[gi].add_here  = fire && (hold_reg.kind == REQ_ADD) && add_ok &&
                                             (count_reg == COUNT_W'(gi));
            assign cell_ctrl[gi].remove_en = fire && (hold_reg.kind == REQ_REMOVE);
            assign exact_vec[gi] = cell_flags[gi].exact;
            assign match_vec[gi] = cell_flags[gi].match;
            assign read_sel[gi]  = hold_reg.index == INDEX_W'(gi);

            wpt_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[gi]),
                .occupied (COUNT_W'(gi) < count_reg),
                .probe    (hold_reg.name),
                .neighbor (cell_neighbor[gi]),
                .seen_in  (seen_chain[gi]),
                .seen_out (seen_chain[gi + 1]),
                .entry    (cell_entry[gi]),
                .flags    (cell_flags[gi])
            );
        end
    endgenerate

    assign any_exact = |exact_vec;
    assign any_match = |match_vec;
    assign index_hit = hold_reg.index < INDEX_W'(count_reg);

    always_comb
    begin
        read_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (read_sel[i])
            begin
                read_entry = read_entry | cell_entry[i];
            end
        end
    end

    // Result of the held item.
    always_comb
    begin
        rsp_next         = '0;
        rsp_next.name_ok = hold_reg.name_ok;
        count_next       = count_reg;
        unique case (hold_reg.kind)
            REQ_ADD:
            begin
                priority if (!hold_reg.name_ok)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (any_exact)
                begin
                    rsp_next.status = ST_EXISTS;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status = ST_OK;
                    count_next      = count_reg + COUNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (any_exact)
                begin
                    rsp_next.status = ST_OK;
                    count_next      = count_reg - COUNT_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            REQ_CONTAINS:
            begin
                rsp_next.status = ST_OK;
                rsp_next.found  = hold_reg.fits && any_match;
            end
            REQ_READ_AT:
            begin
                priority if (hold_reg.room == '0)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (!index_hit)
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
                else if ((LEN_W+1)'(read_entry.length) + (LEN_W+1)'(1) >
                         (LEN_W+1)'(hold_reg.room))
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status       = ST_OK;
                    rsp_next.entry_low    = read_entry.bytes[HALF_BITS-1:0];
                    rsp_next.entry_high   = read_entry.bytes[NAME_BITS-1:HALF_BITS];
                    rsp_next.entry_length = read_entry.length;
                end
            end
            default:
            begin
                rsp_next.status = ST_INVALID;
            end
        endcase
        rsp_next.entry_total = TOTAL_W'(count_next);
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== hw/rtl/wpt_cell.sv =====
// One table cell: holds an entry, compares it with the probe name, shifts on remove.
module wpt_cell
    import wpt_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  logic        occupied,
    input  entry_t      probe,
    input  entry_t      neighbor,
    input  logic        seen_in,
    output logic        seen_out,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t           entry_reg;
    entry_t           entry_next;
    logic [LEN_W-1:0] last_pos;
    logic [7:0]       last_byte;
    logic             star;
    logic             same;
    logic             prefix_ok;
    logic             exact;

    assign last_pos = entry_reg.length - LEN_W'(1);

    always_comb
    begin
        last_byte = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (LEN_W'(b) == last_pos)
            begin
                last_byte = entry_reg.bytes[8*b +: 8];
            end
        end
    end

    // An entry ending in a star matches any name that starts with its other bytes.
    assign star = (entry_reg.length != '0) &&
                  (entry_reg.length <= LEN_W'(NAME_BYTES)) &&
                  (last_byte == CH_STAR);
    assign prefix_ok = (((entry_reg.bytes ^ probe.bytes) & byte_mask(last_pos)) == '0) &&
                       (probe.length >= last_pos);
    assign same  = (entry_reg.length == probe.length) && (entry_reg.bytes == probe.bytes);
    assign exact = occupied && same;

    assign flags.exact = exact;
    assign flags.match = occupied && (star ? prefix_ok : same);
    assign seen_out    = seen_in | exact;
    assign entry       = entry_reg;

    always_comb
    begin
        priority if (ctrl.add_here)
        begin
            entry_next = probe;
        end
        else if (ctrl.remove_en && seen_out)
        begin
            entry_next = neighbor;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/wpt_checker.sv =====
// Port-level assertions for the wildcard permission table, bound to the top level.
module wpt_checker
    import wpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // A request that waits keeps its value.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed");

    // A result that waits keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // Once an item is taken the block works on it before taking another.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted while previous one in progress");

    // The count never exceeds the table size.
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_total <= TOTAL_W'(MAX_ENTRIES))
        else $error("entry count out of range");

    // Entry data and the found flag are returned only with an ok status.
    a_entry_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.entry_length == '0 && rsp.entry_low == '0 && rsp.entry_high == '0 &&
            !rsp.found)
        else $error("entry data or found with failing status");

endmodule

bind wildcard_permission_table wpt_checker u_wpt_checker (.*);

// ===== verif/wildcard_permission_table_test.sv =====
// Self-checking bench for the wildcard permission table: directed and random requests.
module wildcard_permission_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wpt_pkg::*;

    // The cycle budget without any handshake before the run is declared hung. The
    // longest legal quiet stretch is a long sender gap plus a long receiver stall
    // plus a drain pause, so this has ample margin.
    localparam int STUCK_LIMIT = 2000;
    localparam int POOL_SIZE   = 20;
    localparam int SEGMENTS    = 7;
    localparam int SEGMENT_LEN = 100;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    wildcard_permission_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // One request waiting to be offered. The idle count is the number of cycles the
    // sender stays quiet after this item is taken. When the drain flag is set, the
    // sender holds this item back until every outstanding answer has come home.
    typedef struct {
        req_item_t item;
        int        idle_after;
        bit        wait_drain;
    } queued_request_t;

    queued_request_t request_backlog [$];
    rsp_item_t       awaited_replies [$];

    // Shadow copy of the table. Names are kept masked to their length, with byte i
    // at bits 8i, the same layout the request uses with the high half on top.
    logic [NAME_BITS-1:0] table_name [MAX_ENTRIES];
    logic [LEN_W-1:0]     table_len  [MAX_ENTRIES];
    int                   table_count = 0;

    int              failure_count = 0;
    int              stuck_cycles = 0;
    int              hold_left = 0;
    int              stall_left = 0;
    int              calm_left = 0;
    queued_request_t upcoming;
    rsp_item_t       oldest_reply;

    // Stimulus shaping state, used only while the backlog is being filled.
    string pool [POOL_SIZE];
    string charset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_*:";
    bit    no_gaps = 1'b0;
    bit    drain_next = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reset is held at the start of the run and then released for good.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Table behavior
    // ------------------------------------------------------------------------

    // All ones over the first n bytes of a name; a shift by the full width gives zero.
    function automatic logic [NAME_BITS-1:0] lead_mask(int n);
        return {NAME_BITS{1'b1}} >> (8 * (NAME_BYTES - n));
    endfunction

    function automatic bit legal_byte(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               c == CH_DOT || c == CH_DASH || c == CH_UNDER ||
               c == CH_STAR || c == CH_COLON;
    endfunction

    function automatic bit legal_name(logic [NAME_BITS-1:0] name, int len);
        if (len == 0 || len > NAME_BYTES)
            return 1'b0;
        for (int i = 0; i < len; i++)
            if (!legal_byte(name[8*i +: 8]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int exact_slot(logic [NAME_BITS-1:0] name, int len);
        for (int i = 0; i < table_count; i++)
            if (table_len[i] == len && table_name[i] == name)
                return i;
        return -1;
    endfunction

    // An entry that ends in a star grants every name starting with the bytes in front
    // of the star, including the bare prefix itself. A lone star grants everything.
    function automatic bit covered_by(int slot, logic [NAME_BITS-1:0] name, int len);
        int plen;
        plen = table_len[slot];
        if (plen > 0 && table_name[slot][8*(plen-1) +: 8] == CH_STAR)
            return len >= plen - 1 &&
                   ((table_name[slot] ^ name) & lead_mask(plen - 1)) == '0;
        return plen == len && table_name[slot] == name;
    endfunction

    // Applies one request to the shadow table and returns the answer the block owes.
    function automatic rsp_item_t resolve_request(req_item_t r);
        rsp_item_t            reply;
        logic [NAME_BITS-1:0] name;
        int                   len;
        int                   slot;
        reply = '0;
        len = r.name_length;
        name = {r.name_high, r.name_low} & lead_mask(len > NAME_BYTES ? NAME_BYTES : len);
        reply.name_ok = legal_name(name, len);
        reply.status = ST_OK;
        case (r.req_type)
            REQ_ADD:
            begin
                if (!reply.name_ok)
                    reply.status = ST_INVALID;
                else if (exact_slot(name, len) >= 0)
                    reply.status = ST_EXISTS;
                else if (table_count >= MAX_ENTRIES)
                    reply.status = ST_FULL;
                else
                begin
                    table_name[table_count] = name;
                    table_len[table_count] = LEN_W'(len);
                    table_count++;
                end
            end
            REQ_REMOVE:
            begin
                slot = (len > NAME_BYTES) ? -1 : exact_slot(name, len);
                if (slot < 0)
                    reply.status = ST_NOT_FOUND;
                else
                begin
                    // Later entries move down one place so the table stays compact.
                    for (int i = slot; i + 1 < table_count; i++)
                    begin
                        table_name[i] = table_name[i + 1];
                        table_len[i] = table_len[i + 1];
                    end
                    table_count--;
                end
            end
            REQ_CONTAINS:
            begin
                if (len <= NAME_BYTES)
                    for (int i = 0; i < table_count; i++)
                        if (covered_by(i, name, len))
                            reply.found = 1'b1;
            end
            REQ_READ_AT:
            begin
                // The checks run in this order: empty buffer, index past the end,
                // then entry plus terminator too long for the buffer.
                if (r.buffer_room == 0)
                    reply.status = ST_INVALID;
                else if (r.entry_index >= table_count)
                    reply.status = ST_NOT_FOUND;
                else if (table_len[r.entry_index] + 1 > r.buffer_room)
                    reply.status = ST_FULL;
                else
                begin
                    reply.entry_low = table_name[r.entry_index][HALF_BITS-1:0];
                    reply.entry_high = table_name[r.entry_index][NAME_BITS-1:HALF_BITS];
                    reply.entry_length = table_len[r.entry_index];
                end
            end
        endcase
        reply.entry_total = TOTAL_W'(table_count);
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Request sender
    // ------------------------------------------------------------------------

    // The expected answer is worked out at the edge where an item is taken, so the
    // shadow table follows the block in acceptance order. A new item is loaded only
    // when the slot is empty or the current one is being taken at this edge, which
    // keeps a stalled payload steady and gives req_valid one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                awaited_replies.push_back(resolve_request(req));
            if (!req_valid || !req_stall)
            begin
                if (hold_left > 0)
                begin
                    req_valid <= 1'b0;
                    hold_left <= hold_left - 1;
                end
                else if (request_backlog.size() == 0 ||
                         (request_backlog[0].wait_drain && awaited_replies.size() != 0))
                    req_valid <= 1'b0;
                else
                begin
                    upcoming = request_backlog.pop_front();
                    req <= upcoming.item;
                    req_valid <= 1'b1;
                    hold_left <= upcoming.idle_after;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------------

    // Mostly short idle lengths, now and then a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 94)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The receiver stalls in bursts of random length. Every so often it enters a calm
    // stretch with no stalls at all, so back-to-back results are seen as well.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
            calm_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (calm_left > 0)
                calm_left <= calm_left - 1;
            else if ($urandom_range(0, 19) == 0)
                calm_left <= $urandom_range(40, 150);
            else if ($urandom_range(0, 3) == 0)
                stall_left <= idle_span();
        end
    end

    task automatic log_failure(string what);
        failure_count++;
        if (failure_count <= 10)
            $display("%0t: mismatch %0d: %s", $realtime, failure_count, what);
    endtask

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            log_failure($sformatf("%s expected %h, got %h", field, want, got));
    endtask

    // Each taken result is matched against the oldest answer still owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_replies.size() == 0)
                log_failure($sformatf("result with nothing outstanding: %h", rsp));
            else
            begin
                oldest_reply = awaited_replies.pop_front();
                compare_field("status", oldest_reply.status, rsp.status);
                compare_field("found", oldest_reply.found, rsp.found);
                compare_field("name_ok", oldest_reply.name_ok, rsp.name_ok);
                compare_field("entry_low", oldest_reply.entry_low, rsp.entry_low);
                compare_field("entry_high", oldest_reply.entry_high, rsp.entry_high);
                compare_field("entry_length", oldest_reply.entry_length, rsp.entry_length);
                compare_field("entry_total", oldest_reply.entry_total, rsp.entry_total);
            end
        end
    end

    // Ends a hung run: too long without any item moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic string random_text(int len);
        string text;
        int    k;
        text = "";
        for (int i = 0; i < len; i++)
        begin
            k = $urandom_range(0, charset.len() - 1);
            text = {text, charset.substr(k, k)};
        end
        return text;
    endfunction

    function automatic req_item_t make_req(logic [1:0] kind, string text, int index,
                                           int room);
        req_item_t            r;
        logic [NAME_BITS-1:0] name;
        name = '0;
        for (int i = 0; i < text.len() && i < NAME_BYTES; i++)
            name[8*i +: 8] = text[i];
        r = '0;
        r.req_type = kind;
        {r.name_high, r.name_low} = name;
        r.name_length = LEN_W'(text.len());
        r.entry_index = INDEX_W'(index);
        r.buffer_room = ROOM_W'(room);
        return r;
    endfunction

    // Fills the bytes past the name length with junk, which the block must ignore.
    function automatic req_item_t smear(req_item_t r);
        logic [NAME_BITS-1:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom};
        junk = junk & ~lead_mask(r.name_length > NAME_BYTES ? NAME_BYTES : r.name_length);
        {r.name_high, r.name_low} = {r.name_high, r.name_low} | junk;
        return r;
    endfunction

    // Overwrites one byte inside the name, often with zero, often with a bad character.
    function automatic req_item_t poke_byte(req_item_t r, logic [7:0] value);
        logic [NAME_BITS-1:0] name;
        int                   pos;
        name = {r.name_high, r.name_low};
        pos = $urandom_range(0, r.name_length - 1);
        name[8*pos +: 8] = value;
        {r.name_high, r.name_low} = name;
        return r;
    endfunction

    task automatic post(req_item_t r);
        queued_request_t entry;
        entry.item = r;
        entry.idle_after = (no_gaps || $urandom_range(0, 1)) ? 0 : idle_span();
        entry.wait_drain = drain_next;
        drain_next = 1'b0;
        request_backlog.push_back(entry);
    endtask

    // Most random requests work on a small pool of names so adds collide, removes hit
    // and the table fills up. Contains often probes names under a wildcard prefix.
    // A small share is noise: raw random bits, overlong lengths, poked bytes.
    function automatic req_item_t random_request(bit filling);
        req_item_t r;
        string     text;
        int        pick;
        int        which;
        pick = $urandom_range(0, 99);
        which = $urandom_range(0, POOL_SIZE - 1);
        text = pool[which];
        if (pick < (filling ? 45 : 20))
            r = make_req(REQ_ADD, text, 0, 0);
        else if (pick < 50)
            r = make_req(REQ_REMOVE, text, 0, 0);
        else if (pick < 75)
        begin
            if (text[text.len() - 1] == CH_STAR && $urandom_range(0, 1))
                text = {text.substr(0, text.len() - 2),
                        random_text($urandom_range(0, NAME_BYTES + 1 - text.len()))};
            else if ($urandom_range(0, 3) == 0)
                text = random_text($urandom_range(1, NAME_BYTES));
            r = make_req(REQ_CONTAINS, text, 0, 0);
        end
        else if (pick < 90)
        begin
            r = make_req(REQ_READ_AT, "", $urandom_range(0, MAX_ENTRIES + 1),
                         $urandom_range(0, 1) ? 17 : $urandom_range(0, 17));
            if ($urandom_range(0, 7) == 0)
                r.entry_index = INDEX_W'($urandom_range(0, 255));
        end
        else if (pick < 95)
        begin
            r.req_type = 2'($urandom_range(0, 3));
            r.name_low = {$urandom, $urandom};
            r.name_high = {$urandom, $urandom};
            r.name_length = LEN_W'($urandom_range(0, 31));
            r.entry_index = INDEX_W'($urandom_range(0, 255));
            r.buffer_room = ROOM_W'($urandom_range(0, 17));
            return r;
        end
        else
        begin
            r = make_req(2'($urandom_range(0, 2)), text, 0, 0);
            r = poke_byte(r, $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        // Fields that a request does not use still toggle.
        if (r.req_type != REQ_READ_AT)
        begin
            r.entry_index = INDEX_W'($urandom_range(0, 255));
            r.buffer_room = ROOM_W'($urandom_range(0, 17));
        end
        if ($urandom_range(0, 2) == 0)
            r = smear(r);
        return r;
    endfunction

    initial
    begin
        req_item_t r;

        // Directed opening: empty-table answers, the validation rules, exact and
        // wildcard matching, overlong lengths, each read_at outcome, and removal.
        post(make_req(REQ_READ_AT, "", 0, 17));
        post(make_req(REQ_ADD, "", 0, 0));
        post(make_req(REQ_CONTAINS, "dev.eth0", 0, 0));
        post(make_req(REQ_ADD, "a", 0, 0));
        post(make_req(REQ_ADD, "ABCDEFGHIJKLMNOP", 0, 0));
        post(make_req(REQ_ADD, "a", 0, 0));
        post(make_req(REQ_ADD, "no space", 0, 0));
        r = make_req(REQ_ADD, "a0b", 0, 0);
        r.name_low[15:8] = 8'h00;
        post(r);
        post(make_req(REQ_ADD, "dev.*", 0, 0));
        post(make_req(REQ_ADD, "io:port-1_x9", 0, 0));
        post(make_req(REQ_CONTAINS, "dev.eth0", 0, 0));
        post(make_req(REQ_CONTAINS, "dev.", 0, 0));
        post(make_req(REQ_CONTAINS, "dev", 0, 0));
        r = make_req(REQ_CONTAINS, "dev.eth0", 0, 0);
        r.name_length = LEN_W'(NAME_BYTES + 1);
        post(r);
        r.req_type = REQ_ADD;
        post(r);
        r.req_type = REQ_REMOVE;
        post(r);
        post(make_req(REQ_READ_AT, "", 1, 0));
        post(make_req(REQ_READ_AT, "", 1, 16));
        post(make_req(REQ_READ_AT, "", 1, 17));
        post(make_req(REQ_READ_AT, "", 255, 17));
        post(make_req(REQ_ADD, "*", 0, 0));
        post(make_req(REQ_CONTAINS, "zz", 0, 0));
        post(make_req(REQ_REMOVE, "a", 0, 0));
        post(make_req(REQ_REMOVE, "a", 0, 0));
        post(make_req(REQ_REMOVE, "*", 0, 0));
        post(smear(make_req(REQ_ADD, "ab", 0, 0)));
        post(make_req(REQ_CONTAINS, "ab", 0, 0));

        // Name pool: a few wildcard prefixes, many short names, some long ones.
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            if (k < 4)
                pool[k] = {random_text($urandom_range(1, 5)), "*"};
            else if (k < 14)
                pool[k] = random_text($urandom_range(1, 4));
            else
                pool[k] = random_text($urandom_range(5, NAME_BYTES));
        end

        // Random segments alternate between filling and emptying the table. Each one
        // starts only once every answer of the previous one has arrived.
        for (int s = 0; s < SEGMENTS; s++)
        begin
            drain_next = 1'b1;
            for (int n = 0; n < SEGMENT_LEN; n++)
            begin
                if (n % 25 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                post(random_request(s % 2 == 0));
            end
        end

        // Let everything get taken and answered, then allow the pipeline to settle so
        // any stray extra result would still be caught.
        while (request_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failure_count == 0 && awaited_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wpt_pkg.sv
hw/rtl/wpt_cell.sv
hw/rtl/wildcard_permission_table.sv
hw/rtl/wpt_checker.sv
verif/wildcard_permission_table_test.sv
